// ===== rtl/pcg32_bounded_random_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef PCG32_BOUNDED_RANDOM_MACROS_SVH
`define PCG32_BOUNDED_RANDOM_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define PBR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define PBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcg32_pkg.sv =====
package pcg32_pkg;

    localparam int unsigned STATE_W    = 64;
    localparam int unsigned HALF_W     = STATE_W / 2;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned STREAM_W   = 63;
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_TDATA_W = 64;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OUT_PAD_W  = OUT_TDATA_W - WORD_W - 2;
    localparam int unsigned CNT_W      = $clog2(WORD_W);

    localparam logic [STATE_W-1:0] LCG_MULT    = 64'd6364136223846793005;
    localparam logic [HALF_W-1:0]  LCG_MULT_LO = LCG_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0]  LCG_MULT_HI = LCG_MULT[STATE_W-1:HALF_W];
    // seed 0, stream 0: state = (1 + 0) * mult + 1
    localparam logic [STATE_W-1:0] RESET_STATE = LCG_MULT + 64'd1;
    localparam logic [STATE_W-1:0] RESET_INC   = 64'd1;

    localparam int unsigned XSH_SHIFT = 18;
    localparam int unsigned XSH_LOW   = 27;
    localparam int unsigned ROT_LOW   = 59;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RAW     = 2'd0,
        ACT_BOUNDED = 2'd1,
        ACT_CHANCE  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUT,
        S_MUL,
        S_MOD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_LO_LO,
        M_HI_LO,
        M_LO_HI,
        M_ADD
    } t_mstep;

endpackage

// ===== rtl/pcg32_bounded_random.sv =====
// PCG32 generator (64-bit LCG, XSH-RR output) with unbiased range draws.
// Request channel (s_axis): tuser = action (0 raw, 1 bounded, 2 chance),
// tdata = bound then numerator. Result channel (m_axis): tdata = value,
// hit, bound_error. One result per request transfer.
// Config channel: index 0 writes the seed, index 1 the stream; either write
// reseeds the generator; other indexes are ignored. A bounded draw or
// chance test first finds the cutoff 2^32 mod n in the bit-serial
// remainder unit, runs LCG steps until a draw is not below the cutoff,
// then reduces that draw mod n in the same unit. A raw draw is one LCG
// step; a zero bound or unused action goes straight to the result. An
// LCG step is three passes through a single 32x32 multiplier and an add.
// Requests are taken one at a time: s_axis tready is high only while idle
// and no config write is pending. The result sits in an output register;
// if the receiver stalls, the next request is still taken and runs, and
// only its final hand-off waits for the register to drain.
// Reset (synchronous, active low) loads the state seeded from seed 0 and
// stream 0 and drops any pending result.
`include "pcg32_bounded_random_macros.svh"

module pcg32_bounded_random
    import pcg32_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [31:0] bound, [63:32] numerator
    input  logic [ACTION_W-1:0]    i_s_axis_tuser,  // [1:0] action
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [31:0] value, [32] hit,
                                                    // [33] bound_error, [39:34] zero
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [STATE_W-1:0]     i_cfg_data
);

    t_state              r_st, n_st;
    t_mstep              r_mstep, n_mstep;
    t_action             r_action, n_action;
    logic [STATE_W-1:0]  r_seed, n_seed;
    logic [STATE_W-1:0]  r_inc, n_inc;
    logic [STATE_W-1:0]  r_state, n_state;
    logic [STATE_W-1:0]  r_acc, n_acc;
    logic [WORD_W-1:0]   r_draw, n_draw;
    logic [WORD_W-1:0]   r_cutoff, n_cutoff;
    logic [WORD_W-1:0]   r_dvd, n_dvd;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [WORD_W-1:0]   r_bound, n_bound;
    logic [WORD_W-1:0]   r_num, n_num;
    logic                r_seeding, n_seeding;
    logic [WORD_W-1:0]   r_res_value, n_res_value;
    logic                r_res_err, n_res_err;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_value, n_out_value;
    logic                r_out_hit, n_out_hit;
    logic                r_out_err, n_out_err;

    logic [HALF_W-1:0]   w_mul_a;
    logic [HALF_W-1:0]   w_mul_b;
    logic [STATE_W-1:0]  w_prod;
    logic [WORD_W:0]     w_trial;
    logic                w_ge;
    logic [WORD_W-1:0]   w_rem_next;
    logic [STATE_W-1:0]  w_stream_inc;
    logic [WORD_W-1:0]   w_in_bound;
    logic [WORD_W-1:0]   w_in_num;
    logic                w_div_last;

    // XSH-RR output permutation of the pre-step state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] p);
        logic [STATE_W-1:0]  x;
        logic [WORD_W-1:0]   mixed;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] dbl;
        x     = p ^ (p >> XSH_SHIFT);
        mixed = x[XSH_LOW +: WORD_W];
        rot   = p[ROT_LOW +: 5];
        dbl   = {mixed, mixed} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

    assign w_in_bound   = i_s_axis_tdata[WORD_W-1:0];
    assign w_in_num     = i_s_axis_tdata[2*WORD_W-1:WORD_W];
    assign w_stream_inc = {i_cfg_data[STREAM_W-1:0], 1'b1};

    // shared 32x32 multiplier: the three partial products of state * mult mod 2^64
    assign w_mul_a = (r_mstep == M_HI_LO) ? r_state[STATE_W-1:HALF_W] : r_state[HALF_W-1:0];
    assign w_mul_b = (r_mstep == M_LO_HI) ? LCG_MULT_HI : LCG_MULT_LO;
    assign w_prod  = w_mul_a * w_mul_b;

    // restoring remainder, one dividend bit per cycle
    assign w_trial    = {r_rem, r_dvd[WORD_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_bound};
    assign w_rem_next = w_ge ? WORD_W'(w_trial - {1'b0, r_bound}) : w_trial[WORD_W-1:0];
    assign w_div_last = r_cnt == CNT_W'(WORD_W - 1);

    assign o_cfg_ready     = r_st == S_IDLE;
    assign o_s_axis_tready = (r_st == S_IDLE) && !i_cfg_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {OUT_PAD_W'(0), r_out_err, r_out_hit, r_out_value};

    always_comb begin
        n_st        = r_st;
        n_mstep     = r_mstep;
        n_action    = r_action;
        n_seed      = r_seed;
        n_inc       = r_inc;
        n_state     = r_state;
        n_acc       = r_acc;
        n_draw      = r_draw;
        n_cutoff    = r_cutoff;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_bound     = r_bound;
        n_num       = r_num;
        n_seeding   = r_seeding;
        n_res_value = r_res_value;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_hit   = r_out_hit;
        n_out_err   = r_out_err;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_st)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    // reseed collapses to state = (inc + seed) * mult + inc
                    if (i_cfg_index == CFG_SEED) begin
                        n_seed    = i_cfg_data;
                        n_state   = r_inc + i_cfg_data;
                        n_seeding = 1'b1;
                        n_mstep   = M_LO_LO;
                        n_st      = S_MUL;
                    end else if (i_cfg_index == CFG_STREAM) begin
                        n_inc     = w_stream_inc;
                        n_state   = w_stream_inc + r_seed;
                        n_seeding = 1'b1;
                        n_mstep   = M_LO_LO;
                        n_st      = S_MUL;
                    end
                end else if (i_s_axis_tvalid) begin
                    n_action  = t_action'(i_s_axis_tuser);
                    n_bound   = w_in_bound;
                    n_num     = w_in_num;
                    n_seeding = 1'b0;
                    unique case (i_s_axis_tuser)
                        ACT_RAW: begin
                            n_mstep = M_LO_LO;
                            n_st    = S_MUL;
                        end
                        ACT_BOUNDED, ACT_CHANCE: begin
                            if (w_in_bound == '0) begin
                                n_res_value = '0;
                                n_res_err   = 1'b1;
                                n_st        = S_DONE;
                            end else begin
                                n_dvd = WORD_W'(0) - w_in_bound;  // 2^32 - n
                                n_rem = '0;
                                n_cnt = '0;
                                n_st  = S_CUT;
                            end
                        end
                        default: begin
                            n_res_value = '0;
                            n_res_err   = 1'b0;
                            n_st        = S_DONE;
                        end
                    endcase
                end
            end
            S_CUT: begin
                n_rem = w_rem_next;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (w_div_last) begin
                    n_cutoff = w_rem_next;
                    n_mstep  = M_LO_LO;
                    n_st     = S_MUL;
                end
            end
            S_MUL: begin
                unique case (r_mstep)
                    M_LO_LO: begin
                        n_acc   = w_prod;
                        n_draw  = xsh_rr(r_state);
                        n_mstep = M_HI_LO;
                    end
                    M_HI_LO: begin
                        n_acc   = {r_acc[STATE_W-1:HALF_W] + w_prod[HALF_W-1:0],
                                   r_acc[HALF_W-1:0]};
                        n_mstep = M_LO_HI;
                    end
                    M_LO_HI: begin
                        n_acc   = {r_acc[STATE_W-1:HALF_W] + w_prod[HALF_W-1:0],
                                   r_acc[HALF_W-1:0]};
                        n_mstep = M_ADD;
                    end
                    M_ADD: begin
                        n_state = r_acc + r_inc;
                        n_mstep = M_LO_LO;
                        if (r_seeding) begin
                            n_seeding = 1'b0;
                            n_st      = S_IDLE;
                        end else if (r_action == ACT_RAW) begin
                            n_res_value = r_draw;
                            n_res_err   = 1'b0;
                            n_st        = S_DONE;
                        end else if (r_draw >= r_cutoff) begin
                            n_dvd = r_draw;
                            n_rem = '0;
                            n_cnt = '0;
                            n_st  = S_MOD;
                        end
                        // rejected draw: stay for another step
                    end
                    default: n_mstep = M_LO_LO;
                endcase
            end
            S_MOD: begin
                n_rem = w_rem_next;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (w_div_last) begin
                    n_res_value = w_rem_next;
                    n_res_err   = 1'b0;
                    n_st        = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_err   = r_res_err;
                    n_out_hit   = (r_action == ACT_CHANCE) && !r_res_err &&
                                  (r_res_value < r_num);
                    n_st        = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_mstep     <= M_LO_LO;
            r_seeding   <= 1'b0;
            r_out_valid <= 1'b0;
            r_seed      <= '0;
            r_inc       <= RESET_INC;
            r_state     <= RESET_STATE;
        end else begin
            r_st        <= n_st;
            r_mstep     <= n_mstep;
            r_seeding   <= n_seeding;
            r_out_valid <= n_out_valid;
            r_seed      <= n_seed;
            r_inc       <= n_inc;
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_acc       <= n_acc;
        r_draw      <= n_draw;
        r_cutoff    <= n_cutoff;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_bound     <= n_bound;
        r_num       <= n_num;
        r_res_value <= n_res_value;
        r_res_err   <= n_res_err;
        r_out_value <= n_out_value;
        r_out_hit   <= n_out_hit;
        r_out_err   <= n_out_err;
    end

    `PBR_ASSERT_SAME(a_err_clears_result, o_m_axis_tvalid && r_out_err, (r_out_value == '0) && !r_out_hit, "bound error with nonzero value or hit")
    `PBR_ASSERT_SAME(a_rem_below_bound, (r_st == S_CUT) || (r_st == S_MOD), r_rem < r_bound, "remainder not below bound")
    `PBR_ASSERT_NEXT(a_zero_bound_keeps_state, o_s_axis_tready && i_s_axis_tvalid && (i_s_axis_tuser != ACT_RAW) && (i_s_axis_tdata[WORD_W-1:0] == '0), $stable(r_state), "state moved on a rejected request")

endmodule
